// ----- rtl/core/keypad_code_lock_macros.svh -----
// Assertion macros used by the lock checker.
`ifndef KEYPAD_CODE_LOCK_MACROS_SVH
`define KEYPAD_CODE_LOCK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad lock check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad lock check failed");

`endif

// ----- rtl/core/kcl_pkg.sv -----
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int KEY_W    = 8;
  localparam int MASTER_W = 40;
  localparam int POS_W    = 3;
  localparam int WRONG_W  = 2;
  localparam int EVENT_W  = 4;

  // Entry is always five keys long; the master code fills it.
  localparam int ENTRY_LEN = 5;

  localparam logic [KEY_W-1:0]    KEY_START    = 8'd43;  // '+'
  localparam logic [KEY_W-1:0]    KEY_EQUAL    = 8'd61;  // '='
  localparam logic [MASTER_W-1:0] MASTER_RESET = 40'h3132333435;  // "12345"

  // User code after reset, first key in the top byte ("2345")
  localparam int                  USER_RESET_LEN = 4;
  localparam logic [31:0]         USER_RESET     = 32'h32333435;

  typedef enum logic [EVENT_W-1:0] {
    EV_IGNORED       = 4'd0,
    EV_STARTED       = 4'd1,
    EV_KEY_TAKEN     = 4'd2,
    EV_DOOR_OPEN     = 4'd3,
    EV_WRONG_CODE    = 4'd4,
    EV_MASTER_OK     = 4'd5,
    EV_CHANGE_MODE   = 4'd6,
    EV_CHANGE_REFUSE = 4'd7,
    EV_NEW_CODE      = 4'd8
  } event_e;

  // Per-key result from the lock core to the output stage
  typedef struct packed {
    event_e               ev;
    logic [POS_W-1:0]     position;
    logic [WRONG_W-1:0]   wrong_count;
  } kcl_res_t;

  // Reset byte of user code slot i; slots past the default code are zero.
  function automatic logic [KEY_W-1:0] user_reset_byte(int i);
    logic [31:0] w;
    w = '0;
    if (i < USER_RESET_LEN) begin
      w = USER_RESET >> (KEY_W * (USER_RESET_LEN - 1 - i));
    end
    return w[KEY_W-1:0];
  endfunction

endpackage

// ----- rtl/core/kcl_core.sv -----
`timescale 1ns / 1ps

module kcl_core #(
  parameter int CODE_LEN    = 4,
  parameter int WRONG_LIMIT = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [kcl_pkg::KEY_W-1:0]     key_i,
  input  logic [kcl_pkg::MASTER_W-1:0]  master_code_i,
  output kcl_pkg::kcl_res_t             res_o
);
  import kcl_pkg::*;

  localparam int BufN  = (CODE_LEN > ENTRY_LEN) ? CODE_LEN : ENTRY_LEN;
  localparam int IdxW  = $clog2(BufN);
  // Slot that must hold '=' after the user code (only used when it fits)
  localparam int EqIdx = (CODE_LEN < ENTRY_LEN) ? CODE_LEN : 0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ENTRY,
    PH_MASTER,
    PH_NEWCODE
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [POS_W-1:0]     idx_q, idx_d;
  logic [WRONG_W-1:0]   wrong_q, wrong_d;
  logic [WRONG_W:0]     wrong_inc;
  logic [KEY_W-1:0]     user_q [CODE_LEN];
  logic [KEY_W-1:0]     user_d [CODE_LEN];
  logic [KEY_W-1:0]     buf_q  [BufN];
  logic [KEY_W-1:0]     view   [BufN];
  logic                 buf_we;
  logic                 is_master;
  logic                 is_user;

  assign buf_we = step_i && (phase_q == PH_ENTRY || phase_q == PH_NEWCODE);

  // Entry buffer as it stands once this key is written
  always_comb begin
    for (int i = 0; i < BufN; i++) begin
      view[i] = (buf_we && idx_q[IdxW-1:0] == IdxW'(i)) ? key_i : buf_q[i];
    end
  end

  // Master compare over all five entry keys
  always_comb begin
    is_master = 1'b1;
    for (int i = 0; i < ENTRY_LEN; i++) begin
      if (view[i] != master_code_i[MASTER_W-1-KEY_W*i -: KEY_W]) begin
        is_master = 1'b0;
      end
    end
  end

  // User compare: code keys then '=', only when both fit in the entry
  if (CODE_LEN < ENTRY_LEN) begin : g_user_chk
    always_comb begin
      is_user = (view[EqIdx] == KEY_EQUAL);
      for (int i = 0; i < CODE_LEN; i++) begin
        if (view[i] != user_q[i]) begin
          is_user = 1'b0;
        end
      end
    end
  end else begin : g_no_user
    assign is_user = 1'b0;
  end

  // Next state and result for the key at hand
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    wrong_d   = wrong_q;
    user_d    = user_q;
    wrong_inc = {1'b0, wrong_q} + 1'b1;
    res_o.ev       = EV_IGNORED;
    res_o.position = '0;
    unique case (phase_q)
      PH_ENTRY: begin
        res_o.position = idx_q;
        if (idx_q < POS_W'(ENTRY_LEN - 1)) begin
          res_o.ev = EV_KEY_TAKEN;
          idx_d    = idx_q + 1'b1;
        end else if (is_master) begin
          res_o.ev = EV_MASTER_OK;
          phase_d  = PH_MASTER;
          idx_d    = POS_W'(ENTRY_LEN);
        end else if (is_user) begin
          res_o.ev = EV_DOOR_OPEN;
          phase_d  = PH_IDLE;
          idx_d    = '0;
        end else begin
          res_o.ev = EV_WRONG_CODE;
          wrong_d  = (wrong_inc >= (WRONG_W+1)'(WRONG_LIMIT)) ? '0 : wrong_inc[WRONG_W-1:0];
          phase_d  = PH_IDLE;
          idx_d    = '0;
        end
      end
      PH_MASTER: begin
        res_o.position = POS_W'(ENTRY_LEN);
        if (key_i == KEY_EQUAL) begin
          res_o.ev = EV_CHANGE_MODE;
          phase_d  = PH_NEWCODE;
        end else begin
          res_o.ev = EV_CHANGE_REFUSE;
          phase_d  = PH_IDLE;
        end
        idx_d = '0;
      end
      PH_NEWCODE: begin
        res_o.position = idx_q;
        if (idx_q >= POS_W'(CODE_LEN - 1)) begin
          for (int i = 0; i < CODE_LEN; i++) begin
            user_d[i] = view[i];
          end
          res_o.ev = EV_NEW_CODE;
          phase_d  = PH_IDLE;
          idx_d    = '0;
        end else begin
          res_o.ev = EV_KEY_TAKEN;
          idx_d    = idx_q + 1'b1;
        end
      end
      PH_IDLE: begin
        if (key_i == KEY_START) begin
          res_o.ev = EV_STARTED;
          phase_d  = PH_ENTRY;
        end
        idx_d = '0;
      end
      default: begin
        phase_d = PH_IDLE;
        idx_d   = '0;
      end
    endcase
    res_o.wrong_count = wrong_d;
  end

  // Lock state, advanced once per key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      wrong_q <= '0;
      for (int i = 0; i < CODE_LEN; i++) begin
        user_q[i] <= user_reset_byte(i);
      end
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      wrong_q <= wrong_d;
      user_q  <= user_d;
    end
  end

  // Entry buffer, no reset: every slot is written before it is compared
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[idx_q[IdxW-1:0]] <= key_i;
    end
  end

endmodule

// ----- rtl/core/keypad_code_lock.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   key_code_i
// out       output     out_valid_o / out_ready_i event_res_o, key_echo_o, position_o,
//                                                wrong_count_o
// cfg       input      cfg_valid_i / cfg_ready_o master_code_i
//
// One key per cycle sustained while the output is not stalled; a key is taken into the
// input register when accepted and its result into the result register when it steps on.
// The lock state update is one pass of compare and select between those registers.
// Reset clears the state to idle, the user code to "2345", the master code to "12345".
// A stalled output holds its beat; the input register keeps accepting while the
// output beat drains, and stalls only when both are full. cfg_ready_o is always high.

module keypad_code_lock #(
  parameter int CODE_LEN    = 4,
  parameter int WRONG_LIMIT = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kcl_pkg::KEY_W-1:0]         key_code_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kcl_pkg::EVENT_W-1:0]       event_res_o,
  output logic [kcl_pkg::KEY_W-1:0]         key_echo_o,
  output logic [kcl_pkg::POS_W-1:0]         position_o,
  output logic [kcl_pkg::WRONG_W-1:0]       wrong_count_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kcl_pkg::MASTER_W-1:0]      master_code_i
);
  import kcl_pkg::*;

  logic                 in_valid_q;
  logic [KEY_W-1:0]     key_q;
  logic                 out_valid_q;
  kcl_res_t             res_q;
  logic [KEY_W-1:0]     echo_q;
  logic [MASTER_W-1:0]  master_q;
  logic                 step;
  kcl_res_t             res;

  // A key moves on when the result register is free or draining
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign cfg_ready_o = 1'b1;

  kcl_core #(
    .CODE_LEN    (CODE_LEN),
    .WRONG_LIMIT (WRONG_LIMIT)
  ) u_kcl_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .key_i         (key_q),
    .master_code_i (master_q),
    .res_o         (res)
  );

  // Input register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q <= key_code_i;
    end
    if (step) begin
      res_q  <= res;
      echo_q <= key_q;
    end
  end

  // Master code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= MASTER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      master_q <= master_code_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = res_q.ev;
  assign key_echo_o    = echo_q;
  assign position_o    = res_q.position;
  assign wrong_count_o = res_q.wrong_count;

endmodule

// ----- rtl/core/kcl_checker.sv -----
`timescale 1ns / 1ps
`include "keypad_code_lock_macros.svh"

module kcl_checker #(
  parameter int WRONG_LIMIT = 3
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [kcl_pkg::EVENT_W-1:0]  event_res_i,
  input logic [kcl_pkg::POS_W-1:0]    position_i,
  input logic [kcl_pkg::WRONG_W-1:0]  wrong_count_i
);
  import kcl_pkg::*;

  // A stalled result beat stays up
  `KCL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // Attempt counter never reaches the wrap limit
  `KCL_ASSERT_NOW(a_wrong_range, clk_i, rst_ni, out_valid_i, int'(wrong_count_i) < WRONG_LIMIT)

  // Keys ignored while idle report position zero
  `KCL_ASSERT_NOW(a_ignored_pos, clk_i, rst_ni, out_valid_i && event_res_i == EV_IGNORED, position_i == '0)

  // The key after the master code sits just past the entry
  `KCL_ASSERT_NOW(a_after_master_pos, clk_i, rst_ni, out_valid_i && (event_res_i == EV_CHANGE_MODE || event_res_i == EV_CHANGE_REFUSE), position_i == POS_W'(ENTRY_LEN))

endmodule

bind keypad_code_lock kcl_checker #(
  .WRONG_LIMIT (WRONG_LIMIT)
) u_kcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_res_i   (event_res_o),
  .position_i    (position_o),
  .wrong_count_i (wrong_count_o)
);
